// ----- design/double_well_gradient_flow_step_core_defines.svh -----
// ----------------------------------------------------------------------------
// Double-well gradient flow step: assertion macros
// Shared property forms for the concurrent checks of the core.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_WELL_GRADIENT_FLOW_STEP_CORE_DEFINES_SVH
`define DOUBLE_WELL_GRADIENT_FLOW_STEP_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DWGF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DWGF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dwgf_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-well gradient flow step: package
// Fixed-point helpers, configuration register indexes, shared types.
// ----------------------------------------------------------------------------
package dwgf_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 64;
    localparam int DROP_W    = PROD_W - 24;
    localparam int WIDE_W    = 66;

    localparam logic [CFG_IDX_W-1:0] CFG_LATTICE_SPACING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP_TWICE_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WELL_POSITION       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE           = 2'd3;

    localparam logic [CFG_W-1:0] RST_LATTICE_SPACING     = 31'd8388608;
    localparam logic [CFG_W-1:0] RST_RECIP_TWICE_SPACING = 31'd25165824;
    localparam logic [CFG_W-1:0] RST_WELL_POSITION       = 31'd23726566;
    localparam logic [CFG_W-1:0] RST_STEP_SIZE           = 31'd167772;

    // Status of the job queue as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
        logic head_bank;
        logic tail_bank;
    } t_q_stat;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_RUN  = 2'b10
    } t_back_state;

    // Saturate a wide signed value to the signed 32-bit range.
    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[WIDE_W-1:DATA_W-1] == '0 || v[WIDE_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Drop the 24 fraction bits of a product, rounding toward minus infinity.
    function automatic logic signed [DROP_W-1:0] f_drop(input logic signed [PROD_W-1:0] p);
        return p[PROD_W-1:24];
    endfunction

endpackage

// ----- design/dwgf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dwgf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dwgf_front.sv -----
// ----------------------------------------------------------------------------
// Front part
// Takes input items, writes samples into the free bank and posts a job
// when the item that ends the path arrives.
// ----------------------------------------------------------------------------
module dwgf_front
    import dwgf_pkg::*;
#(
    parameter int MAX_SITES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [DATA_W-1:0]            i_sample,
    input  logic                                i_last,
    input  t_q_stat                             i_q_stat,
    output logic                                o_busy,
    output logic                                o_we,
    output logic [$clog2(MAX_SITES):0]          o_waddr,
    output logic [DATA_W-1:0]                   o_wdata,
    output logic                                o_push,
    output logic [$clog2(MAX_SITES+2)-1:0]      o_push_count
);

    localparam int AW = $clog2(MAX_SITES);
    localparam int KW = $clog2(MAX_SITES + 2);

    logic [KW-1:0] r_count;
    logic [KW-1:0] n_count;
    logic          accept;
    logic          room;

    assign accept = i_start && !i_q_stat.full;
    assign room   = r_count < KW'(MAX_SITES);

    assign o_busy       = i_q_stat.full;
    assign o_we         = accept && room;
    assign o_waddr      = {i_q_stat.tail_bank, r_count[AW-1:0]};
    assign o_wdata      = i_sample;
    assign o_push       = accept && i_last;
    assign o_push_count = room ? r_count + KW'(1) : r_count;

    // Samples past the capacity are dropped, but the ending item still posts.
    always_comb begin
        n_count = r_count;
        if (accept) begin
            if (i_last) begin
                n_count = '0;
            end else if (room) begin
                n_count = r_count + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// ----- design/dwgf_queue.sv -----
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of path lengths; each slot owns one bank of the store.
// ----------------------------------------------------------------------------
module dwgf_queue
    import dwgf_pkg::*;
#(
    parameter int KW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [KW-1:0] i_push_count,
    input  logic          i_pop,
    output t_q_stat       o_stat,
    output logic [KW-1:0] o_head_count
);

    logic [KW-1:0] r_slot [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_used;
    logic [1:0]    n_used;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_used = r_used + 2'd1;
            2'b01:   n_used = r_used - 2'd1;
            default: n_used = r_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_used <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_push_count;
        end
    end

    assign o_stat.full      = r_used == 2'd2;
    assign o_stat.empty     = r_used == 2'd0;
    assign o_stat.head_bank = r_rd;
    assign o_stat.tail_bank = r_wr;
    assign o_head_count     = r_slot[r_rd];

endmodule

// ----- design/dwgf_back.sv -----
// ----------------------------------------------------------------------------
// Back part
// Walks the stored path with a three-sample window and runs the update
// pipeline, one site per cycle.
// ----------------------------------------------------------------------------
module dwgf_back
    import dwgf_pkg::*;
#(
    parameter int MAX_SITES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_q_stat                         i_q_stat,
    input  logic [$clog2(MAX_SITES+2)-1:0]  i_head_count,
    input  logic [CFG_W-1:0]                i_lattice_spacing,
    input  logic [CFG_W-1:0]                i_recip_twice_spacing,
    input  logic [CFG_W-1:0]                i_well_position,
    input  logic [CFG_W-1:0]                i_step_size,
    output logic                            o_pop,
    output logic [$clog2(MAX_SITES):0]      o_raddr,
    input  logic [DATA_W-1:0]               i_rdata,
    output logic                            o_valid,
    output logic signed [DATA_W-1:0]        o_sample_out,
    output logic                            o_last_out
);

    localparam int AW    = $clog2(MAX_SITES);
    localparam int KW    = $clog2(MAX_SITES + 2);
    localparam int NSTG  = 7;

    t_back_state r_state;
    t_back_state n_state;
    logic [KW-1:0] r_k;
    logic [KW-1:0] n_k;
    logic [KW-1:0] rd_idx;
    logic          issue;
    logic          last_read;

    logic r_rd_vld;
    logic r_rd_emit;
    logic r_rd_last;

    logic signed [DATA_W-1:0] r_w_prev;
    logic signed [DATA_W-1:0] r_w_cur;
    logic signed [DATA_W-1:0] r_w_next;
    logic                     r_w_vld;
    logic                     r_w_last;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_lst;

    logic signed [DATA_W-1:0] a_s;
    logic signed [DATA_W-1:0] recip_s;
    logic signed [DATA_W-1:0] eta_s;
    logic signed [DATA_W-1:0] eps_s;
    logic signed [DATA_W+1:0] d_raw;

    logic signed [DATA_W-1:0] r1_x;
    logic signed [DATA_W-1:0] r1_d;
    logic signed [PROD_W-1:0] r1_sq_p;
    logic signed [PROD_W-1:0] r1_e2_p;

    logic signed [DATA_W-1:0] sq;
    logic signed [DATA_W-1:0] e2;
    logic signed [DATA_W-1:0] r2_x;
    logic signed [DATA_W-1:0] r2_t;
    logic signed [PROD_W-1:0] r2_lap_p;

    logic signed [PROD_W-1:0] xt_p;
    logic signed [DATA_W-1:0] r3_x;
    logic signed [DATA_W-1:0] r3_dv;
    logic signed [DATA_W-1:0] r3_lap;

    logic signed [DATA_W-1:0] r4_x;
    logic signed [DATA_W-1:0] r4_lap;
    logic signed [PROD_W-1:0] r4_adv_p;

    logic signed [DATA_W-1:0] r5_x;
    logic signed [DATA_W-1:0] r5_g;

    logic signed [DATA_W-1:0] r6_x;
    logic signed [PROD_W-1:0] r6_eg_p;

    logic signed [DATA_W-1:0] r7_out;

    // ------------------------------------------------------------------
    // Read sequencer: x[n-1], x[0] .. x[n-1], x[0], one read per cycle.
    // ------------------------------------------------------------------
    assign issue     = r_state == BK_RUN;
    assign last_read = r_k == i_head_count + KW'(1);
    assign o_pop     = issue && last_read;

    always_comb begin
        if (r_k == '0) begin
            rd_idx = i_head_count - KW'(1);
        end else if (last_read) begin
            rd_idx = '0;
        end else begin
            rd_idx = r_k - KW'(1);
        end
    end

    assign o_raddr = {i_q_stat.head_bank, rd_idx[AW-1:0]};

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            BK_IDLE: begin
                n_k = '0;
                if (!i_q_stat.empty) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                n_k = r_k + KW'(1);
                if (last_read) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
                n_k     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_emit <= 1'b0;
            r_rd_last <= 1'b0;
            r_w_vld   <= 1'b0;
            r_w_last  <= 1'b0;
            r_vld     <= '0;
            r_lst     <= '0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_rd_vld  <= issue;
            r_rd_emit <= issue && (r_k >= KW'(2));
            r_rd_last <= issue && last_read;
            r_w_vld   <= r_rd_vld && r_rd_emit;
            r_w_last  <= r_rd_last;
            r_vld     <= {r_vld[NSTG-2:0], r_w_vld};
            r_lst     <= {r_lst[NSTG-2:0], r_w_last};
        end
    end

    // Sliding window of previous, current and next site.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_w_prev <= r_w_cur;
            r_w_cur  <= r_w_next;
            r_w_next <= i_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Update pipeline.
    // ------------------------------------------------------------------
    assign a_s     = signed'({1'b0, i_lattice_spacing});
    assign recip_s = signed'({1'b0, i_recip_twice_spacing});
    assign eta_s   = signed'({1'b0, i_well_position});
    assign eps_s   = signed'({1'b0, i_step_size});

    assign d_raw = (34'(r_w_cur) <<< 1) - 34'(r_w_prev) - 34'(r_w_next);
    assign sq    = f_sat(WIDE_W'(f_drop(r1_sq_p)));
    assign e2    = f_sat(WIDE_W'(f_drop(r1_e2_p)));
    assign xt_p  = PROD_W'(r2_x) * PROD_W'(r2_t);

    always_ff @(posedge i_clk) begin
        r1_x     <= r_w_cur;
        r1_d     <= f_sat(WIDE_W'(d_raw));
        r1_sq_p  <= PROD_W'(r_w_cur) * PROD_W'(r_w_cur);
        r1_e2_p  <= PROD_W'(eta_s) * PROD_W'(eta_s);

        r2_x     <= r1_x;
        r2_t     <= f_sat(WIDE_W'(sq) - WIDE_W'(e2));
        r2_lap_p <= PROD_W'(r1_d) * PROD_W'(recip_s);

        r3_x     <= r2_x;
        r3_dv    <= f_sat(WIDE_W'(f_drop(xt_p)) <<< 2);
        r3_lap   <= f_sat(WIDE_W'(f_drop(r2_lap_p)));

        r4_x     <= r3_x;
        r4_lap   <= r3_lap;
        r4_adv_p <= PROD_W'(a_s) * PROD_W'(r3_dv);

        r5_x     <= r4_x;
        r5_g     <= f_sat(WIDE_W'(r4_lap) + WIDE_W'(f_sat(WIDE_W'(f_drop(r4_adv_p)))));

        r6_x     <= r5_x;
        r6_eg_p  <= PROD_W'(eps_s) * PROD_W'(r5_g);

        r7_out   <= f_sat(WIDE_W'(r6_x) - WIDE_W'(f_sat(WIDE_W'(f_drop(r6_eg_p)))));
    end

    assign o_valid      = r_vld[NSTG-1];
    assign o_last_out   = r_vld[NSTG-1] && r_lst[NSTG-1];
    assign o_sample_out = r7_out;

endmodule

// ----- design/double_well_gradient_flow_step_core.sv -----
// ----------------------------------------------------------------------------
// Double-well gradient flow step core
// One gradient-descent step of the discretized double-well lattice action
// over a periodic path of signed Q8.24 samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (sample, last flag) are taken on start while busy is low,
//   one per cycle. The item with the last flag ends the path; up to
//   MAX_SITES samples are kept, later ones are dropped.
//   The store has two banks, so a second path can be loaded while the first
//   is processed. busy rises only while two finished paths are waiting.
//   Results come out in site order, one per cycle, each on o_valid for one
//   cycle, with o_last_out on the final site. The read port walks each path
//   once with a wrap-around sample at each end and sets the back-end rate.
//   The receiver cannot stall; results are never held. Configuration is
//   written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
//   it only while the core is idle, which the core does not enforce.
//   Reset restores the register defaults and empties the queue; stored
//   samples are left as they are.
// ----------------------------------------------------------------------------
`include "double_well_gradient_flow_step_core_defines.svh"

module double_well_gradient_flow_step_core
    import dwgf_pkg::*;
#(
    parameter int MAX_SITES = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_sample_in,
    input  logic                     i_last_in,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_sample_out,
    output logic                     o_last_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    localparam int AW        = $clog2(MAX_SITES);
    localparam int KW        = $clog2(MAX_SITES + 2);
    localparam int RAM_DEPTH = 2 * (2 ** AW);

    logic [CFG_W-1:0] r_lattice_spacing;
    logic [CFG_W-1:0] r_recip_twice_spacing;
    logic [CFG_W-1:0] r_well_position;
    logic [CFG_W-1:0] r_step_size;

    t_q_stat       q_stat;
    logic [KW-1:0] head_count;
    logic          q_push;
    logic [KW-1:0] push_count;
    logic          q_pop;

    logic              ram_we;
    logic [AW:0]       ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW:0]       ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lattice_spacing     <= RST_LATTICE_SPACING;
            r_recip_twice_spacing <= RST_RECIP_TWICE_SPACING;
            r_well_position       <= RST_WELL_POSITION;
            r_step_size           <= RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LATTICE_SPACING:     r_lattice_spacing     <= i_cfg_data;
                CFG_RECIP_TWICE_SPACING: r_recip_twice_spacing <= i_cfg_data;
                CFG_WELL_POSITION:       r_well_position       <= i_cfg_data;
                CFG_STEP_SIZE:           r_step_size           <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dwgf_front #(
        .MAX_SITES (MAX_SITES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_sample     (i_sample_in),
        .i_last       (i_last_in),
        .i_q_stat     (q_stat),
        .o_busy       (busy),
        .o_we         (ram_we),
        .o_waddr      (ram_waddr),
        .o_wdata      (ram_wdata),
        .o_push       (q_push),
        .o_push_count (push_count)
    );

    dwgf_queue #(
        .KW (KW)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_count (push_count),
        .i_pop        (q_pop),
        .o_stat       (q_stat),
        .o_head_count (head_count)
    );

    dwgf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_path_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dwgf_back #(
        .MAX_SITES (MAX_SITES)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_q_stat              (q_stat),
        .i_head_count          (head_count),
        .i_lattice_spacing     (r_lattice_spacing),
        .i_recip_twice_spacing (r_recip_twice_spacing),
        .i_well_position       (r_well_position),
        .i_step_size           (r_step_size),
        .o_pop                 (q_pop),
        .o_raddr               (ram_raddr),
        .i_rdata               (ram_rdata),
        .o_valid               (o_valid),
        .o_sample_out          (o_sample_out),
        .o_last_out            (o_last_out)
    );

    // Paths are never posted into a full queue nor taken from an empty one,
    // and the read sequencer always leaves a gap between two paths.
    `DWGF_ASSERT_SAME(a_push_room, i_clk, i_rst_n, q_push, !q_stat.full, "job pushed into full queue")
    `DWGF_ASSERT_SAME(a_pop_job, i_clk, i_rst_n, q_pop, !q_stat.empty, "job popped from empty queue")
    `DWGF_ASSERT_NEXT(a_path_gap, i_clk, i_rst_n, o_valid && o_last_out, !o_valid, "no gap after path end")

endmodule
